// File: rtl/spk_pkg.sv
// ----------------------------------------------------------------------------
// spk_pkg: shared types, codes and round functions
// Speck128/128 word rotates, one forward and one inverse round, register
// indexes, command and mode codes for the block cipher unit.
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int ROUNDS     = 32;
  localparam int WORD_W     = 64;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DECRYPT   = 2'd3;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BLOCK = 1'b1;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_OFB = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } spk_pair_t;

  // Round unit control
  typedef struct packed {
    logic load;
    logic step;
    logic inverse;
  } spk_rctl_t;

  function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] v);
    return {v[7:0], v[WORD_W-1:8]};
  endfunction

  function automatic logic [WORD_W-1:0] rol8(input logic [WORD_W-1:0] v);
    return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
  endfunction

  function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] v);
    return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
  endfunction

  function automatic logic [WORD_W-1:0] ror3(input logic [WORD_W-1:0] v);
    return {v[2:0], v[WORD_W-1:3]};
  endfunction

  // x = (ror(x,8) + y) ^ k ; y = rol(y,3) ^ x
  function automatic spk_pair_t enc_round(input logic [WORD_W-1:0] x,
                                          input logic [WORD_W-1:0] y,
                                          input logic [WORD_W-1:0] k);
    spk_pair_t r;
    r.hi = (ror8(x) + y) ^ k;
    r.lo = rol3(y) ^ r.hi;
    return r;
  endfunction

  // y = ror(y ^ x, 3) ; x = rol((x ^ k) - y, 8)
  function automatic spk_pair_t dec_round(input logic [WORD_W-1:0] x,
                                          input logic [WORD_W-1:0] y,
                                          input logic [WORD_W-1:0] k);
    spk_pair_t r;
    r.lo = ror3(y ^ x);
    r.hi = rol8((x ^ k) - r.lo);
    return r;
  endfunction

endpackage

// File: rtl/speck128_block_cipher_modes.sv
// ----------------------------------------------------------------------------
// speck128_block_cipher_modes: Speck128/128 unit with ECB, CBC and OFB
// Key schedule into a round key memory, one shared round, chaining logic.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 key_low,
//   1 key_high, 2 cipher_mode, 3 decrypt_select). Write only while idle.
//   Requests enter on s_axis_*: tuser is the command (0 load chain, 1 block),
//   tdata the 128-bit block. Results leave on m_axis_* for block commands only.
//   A load request sets the chain and gives no result.
//   A block request is accepted in idle, primes the round key memory read,
//   runs 32 rounds on the shared round unit (one per cycle, keyed by the
//   memory's read port) and finishes the chaining; the next request is taken
//   once it is back in idle. The result enters the output register as it leaves the finish state.
//   The first block after reset or after a key write first runs the key
//   schedule in the expand state, one round key written per cycle.
//   Reset clears the configuration registers, the state, the chain, the output
//   valid flag and the keys-ready flag; the key memory holds nothing valid until the schedule has run.
//   The result sits in an output register; new requests are taken while it
//   waits. If the receiver still stalls when the next block finishes, hold
//   that block in the finish state until the register frees.
// ----------------------------------------------------------------------------
module speck128_block_cipher_modes #(
  parameter int ROUNDS = spk_pkg::ROUNDS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [spk_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [spk_pkg::WORD_W-1:0]       cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [2*spk_pkg::WORD_W-1:0]     s_axis_tdata,  // word_low, word_high
  input  logic                             s_axis_tuser,  // command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [2*spk_pkg::WORD_W-1:0]     m_axis_tdata   // out_low, out_high
);

  localparam int W  = spk_pkg::WORD_W;
  localparam int CW = $clog2(ROUNDS);
  localparam logic [CW-1:0] LAST = CW'(ROUNDS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_PRIME  = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [W-1:0] key_low;
  logic [W-1:0] key_high;
  logic [1:0]   cipher_mode;
  logic         decrypt_select;
  logic         keys_ready;

  // Chain and held request words
  logic [W-1:0] chain_low;
  logic [W-1:0] chain_high;
  logic [W-1:0] word_low;
  logic [W-1:0] word_high;

  logic [CW-1:0] cnt;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] rd_addr;

  logic          accept;
  logic          exp_start;
  logic          exp_done;
  logic          key_we;
  logic [CW-1:0] key_waddr;
  logic [W-1:0]  key_wdata;
  logic [W-1:0]  rkey;

  spk_pkg::spk_rctl_t rctl;
  logic [W-1:0] init_hi;
  logic [W-1:0] init_lo;
  logic [W-1:0] res_hi;
  logic [W-1:0] res_lo;

  logic         inverse;
  logic         out_load;
  logic [W-1:0] out_low_next;
  logic [W-1:0] out_high_next;
  logic [W-1:0] out_low;
  logic [W-1:0] out_high;
  logic         out_valid;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign exp_start     = accept && (s_axis_tuser == spk_pkg::CMD_BLOCK) && !keys_ready;

  // OFB runs the forward cipher in both directions
  assign inverse = decrypt_select && (cipher_mode != spk_pkg::MODE_OFB);

  // Configuration port; a key write drops the expanded keys
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low        <= '0;
      key_high       <= '0;
      cipher_mode    <= spk_pkg::MODE_ECB;
      decrypt_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        spk_pkg::REG_KEY_LOW:  key_low        <= cfg_wdata;
        spk_pkg::REG_KEY_HIGH: key_high       <= cfg_wdata;
        spk_pkg::REG_MODE:     cipher_mode    <= cfg_wdata[1:0];
        spk_pkg::REG_DECRYPT:  decrypt_select <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_ready <= 1'b0;
    end else if (cfg_we && (cfg_addr == spk_pkg::REG_KEY_LOW ||
                            cfg_addr == spk_pkg::REG_KEY_HIGH)) begin
      keys_ready <= 1'b0;
    end else if (exp_done) begin
      keys_ready <= 1'b1;
    end
  end

  spk_key_exp #(.ROUNDS(ROUNDS)) u_key_exp (
    .clk      (clk),
    .rst      (rst),
    .start    (exp_start),
    .key_low  (key_low),
    .key_high (key_high),
    .we       (key_we),
    .waddr    (key_waddr),
    .wdata    (key_wdata),
    .done     (exp_done)
  );

  // Read one round ahead: prime fetches round 0, each round fetches the next
  assign rd_cnt  = (state == ST_ROUND) ? cnt + 1'b1 : cnt;
  assign rd_addr = inverse ? (LAST - rd_cnt) : rd_cnt;

  spk_key_mem #(.ROUNDS(ROUNDS)) u_key_mem (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (rkey)
  );

  // Cipher input per mode: CBC encrypt whitens with the chain, OFB ciphers it
  always_comb begin
    init_hi = word_high;
    init_lo = word_low;
    if (cipher_mode == spk_pkg::MODE_CBC && !decrypt_select) begin
      init_hi = word_high ^ chain_high;
      init_lo = word_low ^ chain_low;
    end else if (cipher_mode == spk_pkg::MODE_OFB) begin
      init_hi = chain_high;
      init_lo = chain_low;
    end
  end

  assign rctl.load    = (state == ST_PRIME);
  assign rctl.step    = (state == ST_ROUND);
  assign rctl.inverse = inverse;

  spk_round_unit u_round (
    .clk     (clk),
    .ctl     (rctl),
    .init_hi (init_hi),
    .init_lo (init_lo),
    .rkey    (rkey),
    .res_hi  (res_hi),
    .res_lo  (res_lo)
  );

  // Result per mode
  always_comb begin
    out_high_next = res_hi;
    out_low_next  = res_lo;
    if (cipher_mode == spk_pkg::MODE_CBC && decrypt_select) begin
      out_high_next = res_hi ^ chain_high;
      out_low_next  = res_lo ^ chain_low;
    end else if (cipher_mode == spk_pkg::MODE_OFB) begin
      out_high_next = word_high ^ res_hi;
      out_low_next  = word_low ^ res_lo;
    end
  end

  assign out_load = (state == ST_FINISH) && (!out_valid || m_axis_tready);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_axis_tuser == spk_pkg::CMD_BLOCK) begin
          state_next = keys_ready ? ST_PRIME : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (exp_done) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: state_next = ST_ROUND;
      ST_ROUND: begin
        if (cnt == LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_PRIME) begin
        cnt <= '0;
      end else if (state == ST_ROUND) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Hold the request words for chaining and the OFB xor
  always_ff @(posedge clk) begin
    if (accept) begin
      word_low  <= s_axis_tdata[W-1:0];
      word_high <= s_axis_tdata[2*W-1:W];
    end
  end

  // Chain update: load command, CBC and OFB at block finish
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_low  <= '0;
      chain_high <= '0;
    end else if (accept && s_axis_tuser == spk_pkg::CMD_LOAD) begin
      chain_low  <= s_axis_tdata[W-1:0];
      chain_high <= s_axis_tdata[2*W-1:W];
    end else if (out_load) begin
      if (cipher_mode == spk_pkg::MODE_CBC) begin
        chain_low  <= decrypt_select ? word_low : res_lo;
        chain_high <= decrypt_select ? word_high : res_hi;
      end else if (cipher_mode == spk_pkg::MODE_OFB) begin
        chain_low  <= res_lo;
        chain_high <= res_hi;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_low  <= out_low_next;
      out_high <= out_high_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_high, out_low};

`ifndef SYNTHESIS
  a_rounds_need_keys: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND || state == ST_PRIME) |-> keys_ready)
    else $error("round key read before the schedule completed");

  a_key_write_drops_keys: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_addr == spk_pkg::REG_KEY_LOW || cfg_addr == spk_pkg::REG_KEY_HIGH))
      |=> !keys_ready)
    else $error("keys still marked ready after a key write");

  a_schedule_in_expand: assert property (@(posedge clk) disable iff (rst)
    key_we == (state == ST_EXPAND))
    else $error("key schedule writes outside the expand state");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_axis_tvalid && state == ST_IDLE))
    else $error("finished block not placed in the output register");
`endif

endmodule

// File: rtl/spk_key_mem.sv
// ----------------------------------------------------------------------------
// spk_key_mem: round key memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spk_key_mem #(
  parameter int ROUNDS = spk_pkg::ROUNDS
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(ROUNDS)-1:0]   waddr,
  input  logic [spk_pkg::WORD_W-1:0]  wdata,
  input  logic [$clog2(ROUNDS)-1:0]   raddr,
  output logic [spk_pkg::WORD_W-1:0]  rdata
);

  logic [spk_pkg::WORD_W-1:0] mem [ROUNDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/spk_key_exp.sv
// ----------------------------------------------------------------------------
// spk_key_exp: key schedule sequencer
// Walks the key schedule one round a cycle and writes each round key.
// ----------------------------------------------------------------------------
module spk_key_exp #(
  parameter int ROUNDS = spk_pkg::ROUNDS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [spk_pkg::WORD_W-1:0]  key_low,
  input  logic [spk_pkg::WORD_W-1:0]  key_high,
  output logic                        we,
  output logic [$clog2(ROUNDS)-1:0]   waddr,
  output logic [spk_pkg::WORD_W-1:0]  wdata,
  output logic                        done
);

  localparam int CW = $clog2(ROUNDS);
  localparam logic [CW-1:0] LAST = CW'(ROUNDS - 1);

  logic [spk_pkg::WORD_W-1:0] a;
  logic [spk_pkg::WORD_W-1:0] b;
  logic [CW-1:0]              cnt;
  logic                       busy;
  spk_pkg::spk_pair_t         nxt;

  // The schedule step is a forward round keyed by the round number
  assign nxt   = spk_pkg::enc_round(b, a, spk_pkg::WORD_W'(cnt));
  assign we    = busy;
  assign waddr = cnt;
  assign wdata = a;
  assign done  = busy && (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= key_low;
      b <= key_high;
    end else if (busy) begin
      a <= nxt.lo;
      b <= nxt.hi;
    end
  end

endmodule

// File: rtl/spk_round_unit.sv
// ----------------------------------------------------------------------------
// spk_round_unit: shared cipher round
// Holds the block state and applies one forward or inverse round per step.
// ----------------------------------------------------------------------------
module spk_round_unit (
  input  logic                        clk,
  input  spk_pkg::spk_rctl_t          ctl,
  input  logic [spk_pkg::WORD_W-1:0]  init_hi,
  input  logic [spk_pkg::WORD_W-1:0]  init_lo,
  input  logic [spk_pkg::WORD_W-1:0]  rkey,
  output logic [spk_pkg::WORD_W-1:0]  res_hi,
  output logic [spk_pkg::WORD_W-1:0]  res_lo
);

  logic [spk_pkg::WORD_W-1:0] x;
  logic [spk_pkg::WORD_W-1:0] y;
  spk_pkg::spk_pair_t         fwd;
  spk_pkg::spk_pair_t         inv;

  assign fwd    = spk_pkg::enc_round(x, y, rkey);
  assign inv    = spk_pkg::dec_round(x, y, rkey);
  assign res_hi = x;
  assign res_lo = y;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= init_hi;
      y <= init_lo;
    end else if (ctl.step) begin
      x <= ctl.inverse ? inv.hi : fwd.hi;
      y <= ctl.inverse ? inv.lo : fwd.lo;
    end
  end

endmodule
